// ===== design/gnl_pkg.sv =====
// shared types, codes and helpers for the grid neighbor lister
`timescale 1ns / 1ps

package gnl_pkg;

  // default grid store size
  localparam int GNL_MAX_COLS = 256;
  localparam int GNL_MAX_ROWS = 256;

  // neighbors of one cell: four sides, then four diagonals
  localparam int NB_LIMIT = 8;
  localparam int NB_IDX_W = 3;

  // input item modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_LIST  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_GRID_WIDTH    = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_DIAGONAL_RULE = 2'd2;

  // diagonal rule codes
  localparam logic [1:0] DIAG_NONE      = 2'd0;
  localparam logic [1:0] DIAG_BOTH_OPEN = 2'd1;
  localparam logic [1:0] DIAG_ONE_OPEN  = 2'd2;
  localparam logic [1:0] DIAG_ALL       = 2'd3;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_QUERY,
    KIND_LIST
  } kind_t;

  // one classified item waiting for the back end
  typedef struct packed {
    kind_t      kind;
    logic [7:0] col;
    logic [7:0] row;
    logic       cell_open;
  } q_item_t;

  // one result beat
  typedef struct packed {
    logic       found;
    logic [7:0] col;
    logic [7:0] row;
    logic       last;
  } res_t;

  // column step of neighbor i
  function automatic logic [1:0] nb_dx(input logic [NB_IDX_W-1:0] i);
    logic [1:0] d;
    case (i)
      3'd1, 3'd5, 3'd6: d = 2'b01;
      3'd3, 3'd4, 3'd7: d = 2'b11;
      default:          d = 2'b00;
    endcase
    return d;
  endfunction

  // row step of neighbor i, up is row - 1
  function automatic logic [1:0] nb_dy(input logic [NB_IDX_W-1:0] i);
    logic [1:0] d;
    case (i)
      3'd0, 3'd4, 3'd5: d = 2'b11;
      3'd2, 3'd6, 3'd7: d = 2'b01;
      default:          d = 2'b00;
    endcase
    return d;
  endfunction

  // coordinate plus a step of -1, 0 or +1, kept as 10-bit two's complement
  function automatic logic [9:0] step_coord(input logic [7:0] c, input logic [1:0] d);
    return {2'b00, c} + {{8{d[1]}}, d};
  endfunction

  // coordinate lies in 0 .. min(limit, store size) - 1
  function automatic logic coord_in(input logic [9:0] v, input logic [8:0] lim,
                                    input logic [12:0] maxv);
    return !v[9] && (v[8:0] < lim) && ({4'b0000, v[8:0]} < maxv);
  endfunction

endpackage

// ===== design/gnl_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module gnl_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/gnl_front.sv =====
// input side: accepts items, drops the ones without effect, queues the rest
`timescale 1ns / 1ps

module gnl_front #(
  parameter int MAX_COLS = gnl_pkg::GNL_MAX_COLS,
  parameter int MAX_ROWS = gnl_pkg::GNL_MAX_ROWS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             hold,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_mode,
  input  logic [7:0]       in_col,
  input  logic [7:0]       in_row,
  input  logic             in_cell_open,
  input  logic [8:0]       grid_width,
  input  logic [8:0]       grid_height,
  output logic             q_valid,
  output gnl_pkg::q_item_t q_item,
  input  logic             q_pop
);

  import gnl_pkg::*;

  localparam logic [12:0] MaxC = 13'(MAX_COLS);
  localparam logic [12:0] MaxR = 13'(MAX_ROWS);

  q_item_t    entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  logic    keep;
  logic    push;
  q_item_t item_in;

  always_comb begin
    item_in.col       = in_col;
    item_in.row       = in_row;
    item_in.cell_open = in_cell_open;
    item_in.kind      = KIND_WRITE;
    keep              = 1'b0;
    case (in_mode)
      MODE_WRITE: begin
        item_in.kind = KIND_WRITE;
        // writes outside the grid in use have no effect
        keep = coord_in({2'b00, in_col}, grid_width, MaxC) &&
               coord_in({2'b00, in_row}, grid_height, MaxR);
      end
      MODE_QUERY: begin
        item_in.kind = KIND_QUERY;
        keep         = 1'b1;
      end
      MODE_LIST: begin
        item_in.kind = KIND_LIST;
        keep         = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready = !hold && (count != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        entries[wptr] <= item_in;
        wptr          <= !wptr;
      end
      if (q_pop) begin
        rptr <= !rptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/gnl_back.sv =====
// execution side: clears the cell map, runs writes, reads and emits results
`timescale 1ns / 1ps

module gnl_back #(
  parameter int MAX_COLS = gnl_pkg::GNL_MAX_COLS,
  parameter int MAX_ROWS = gnl_pkg::GNL_MAX_ROWS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  gnl_pkg::q_item_t q_item,
  output logic             q_pop,
  input  logic [8:0]       grid_width,
  input  logic [8:0]       grid_height,
  input  logic [1:0]       diagonal_rule,
  output logic             clearing,
  output logic             res_valid,
  output gnl_pkg::res_t    res,
  input  logic             res_ready
);

  import gnl_pkg::*;

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int AW    = CW + RW;
  localparam int DEPTH = 2 ** AW;

  localparam logic [12:0] MaxC = 13'(MAX_COLS);
  localparam logic [12:0] MaxR = 13'(MAX_ROWS);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EMIT
  } state_t;

  state_t                state;
  logic [AW-1:0]         clr_addr;
  q_item_t               cur;
  logic [NB_IDX_W-1:0]   idx;
  logic                  iss_done;
  logic                  p_valid;
  logic [NB_IDX_W-1:0]   p_idx;
  logic                  p_in;
  logic                  p_last;
  logic [3:0]            side;
  logic [NB_LIMIT-1:0]   mask;
  logic                  cq_found;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic                  wdata;
  logic [AW-1:0]         raddr;
  logic                  rdata;

  logic [1:0]            rd_dx;
  logic [1:0]            rd_dy;
  logic [9:0]            rd_x;
  logic [9:0]            rd_y;
  logic                  rd_in;
  logic                  issue;
  logic                  issue_last;
  logic                  ok_bit;
  logic [1:0]            dj;
  logic                  side_a;
  logic                  side_b;
  logic                  allow;

  logic [NB_IDX_W-1:0]   sel;
  logic [NB_LIMIT-1:0]   rest;
  logic [9:0]            em_x;
  logic [9:0]            em_y;
  logic                  emit_ok;
  logic                  emit_go;

  gnl_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign clearing = (state == S_CLEAR);
  assign q_pop    = (state == S_IDLE) && q_valid;

  // write port: clearing pass, or a write item taken from the queue
  always_comb begin
    we    = 1'b0;
    waddr = clr_addr;
    wdata = 1'b1;
    if (state == S_CLEAR) begin
      we = 1'b1;
    end else if (q_pop && (q_item.kind == KIND_WRITE)) begin
      we    = 1'b1;
      waddr = {RW'(q_item.row), CW'(q_item.col)};
      wdata = q_item.cell_open;
    end
  end

  // read address: the cell itself for a query, neighbor idx for a list
  always_comb begin
    rd_dx      = (cur.kind == KIND_LIST) ? nb_dx(idx) : 2'b00;
    rd_dy      = (cur.kind == KIND_LIST) ? nb_dy(idx) : 2'b00;
    rd_x       = step_coord(cur.col, rd_dx);
    rd_y       = step_coord(cur.row, rd_dy);
    rd_in      = coord_in(rd_x, grid_width, MaxC) && coord_in(rd_y, grid_height, MaxR);
    raddr      = {RW'(rd_y[8:0]), CW'(rd_x[8:0])};
    issue      = (state == S_READ) && !iss_done;
    issue_last = (cur.kind != KIND_LIST) || (idx == NB_IDX_W'(NB_LIMIT - 1));
  end

  // diagonal j sits between sides j-1 and j (mod 4)
  always_comb begin
    ok_bit = p_in && rdata;
    dj     = p_idx[1:0];
    side_a = side[dj - 2'd1];
    side_b = side[dj];
    case (diagonal_rule)
      DIAG_BOTH_OPEN: allow = side_a && side_b;
      DIAG_ONE_OPEN:  allow = side_a || side_b;
      DIAG_ALL:       allow = 1'b1;
      default:        allow = 1'b0;
    endcase
  end

  // lowest listed neighbor goes out first
  always_comb begin
    sel = '0;
    for (int k = NB_LIMIT - 1; k >= 0; k--) begin
      if (mask[k]) begin
        sel = NB_IDX_W'(k);
      end
    end
    rest    = mask & ~(NB_LIMIT'(1) << sel);
    em_x    = step_coord(cur.col, nb_dx(sel));
    em_y    = step_coord(cur.row, nb_dy(sel));
    emit_ok = !res_valid || res_ready;
    emit_go = (state == S_EMIT) && emit_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      res_valid <= 1'b0;
      iss_done  <= 1'b0;
      p_valid   <= 1'b0;
    end else begin
      if (emit_go) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cur      <= q_item;
            idx      <= '0;
            iss_done <= 1'b0;
            p_valid  <= 1'b0;
            mask     <= '0;
            if (q_item.kind != KIND_WRITE) begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          p_valid <= issue;
          if (issue) begin
            p_idx  <= idx;
            p_in   <= rd_in;
            p_last <= issue_last;
            idx    <= idx + NB_IDX_W'(1);
            if (issue_last) begin
              iss_done <= 1'b1;
            end
          end
          if (p_valid) begin
            if (cur.kind != KIND_LIST) begin
              cq_found <= ok_bit;
            end else if (!p_idx[2]) begin
              side[p_idx[1:0]] <= ok_bit;
              mask[p_idx]      <= ok_bit;
            end else begin
              mask[p_idx] <= ok_bit && allow;
            end
            if (p_last) begin
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            if (cur.kind != KIND_LIST) begin
              res   <= '{found: cq_found, col: cur.col, row: cur.row, last: 1'b1};
              state <= S_IDLE;
            end else if (mask == '0) begin
              res   <= '{found: 1'b0, col: cur.col, row: cur.row, last: 1'b1};
              state <= S_IDLE;
            end else begin
              res  <= '{found: 1'b1, col: em_x[7:0], row: em_y[7:0], last: (rest == '0)};
              mask <= rest;
              if (rest == '0) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/grid_neighbor_lister_core.sv =====
// top level of the grid neighbor lister: ports, configuration registers, front and back
`timescale 1ns / 1ps

// Keeps one open/blocked bit per cell of a MAX_COLS x MAX_ROWS grid in a one-write, one-read
// bit memory and answers cell writes, cell queries and eight-neighbor lists. After reset the
// block runs a clearing pass that marks every cell open, one cell a cycle, covering all
// 2**(clog2(MAX_COLS) + clog2(MAX_ROWS)) cells (65536 at the defaults); s_tready stays low
// during it, configuration writes are taken throughout. Afterwards items are handled one at
// a time by the back end, whose pace is set by the one read a cycle of the bit memory: a
// write needs no read, a cell query reads the cell itself, a neighbor list reads the eight
// neighbors and then gives 1 to 8 result beats. A two-entry queue and an output register let
// the input take items until the queue is full while a result waits on m_tready.
// Writes outside the grid in use and mode 3 are dropped at the input and give no beat.

module grid_neighbor_lister_core #(
  parameter int MAX_COLS = gnl_pkg::GNL_MAX_COLS,
  parameter int MAX_ROWS = gnl_pkg::GNL_MAX_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // col [7:0], row [15:8], cell_open [16], zero [23:17]
  input  logic [1:0]  s_tuser,   // mode [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // nb_col [7:0], nb_row [15:8]
  output logic [0:0]  m_tuser,   // found [0]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  import gnl_pkg::*;

  logic [8:0] grid_width;
  logic [8:0] grid_height;
  logic [1:0] diagonal_rule;

  logic    clearing;
  logic    q_valid;
  q_item_t q_item;
  logic    q_pop;
  res_t    res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width    <= 9'd256;
      grid_height   <= 9'd256;
      diagonal_rule <= DIAG_NONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_WIDTH:    grid_width    <= cfg_data;
        REG_GRID_HEIGHT:   grid_height   <= cfg_data;
        REG_DIAGONAL_RULE: diagonal_rule <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  gnl_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .hold         (clearing),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_mode      (s_tuser),
    .in_col       (s_tdata[7:0]),
    .in_row       (s_tdata[15:8]),
    .in_cell_open (s_tdata[16]),
    .grid_width   (grid_width),
    .grid_height  (grid_height),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  gnl_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .grid_width    (grid_width),
    .grid_height   (grid_height),
    .diagonal_rule (diagonal_rule),
    .clearing      (clearing),
    .res_valid     (m_tvalid),
    .res           (res),
    .res_ready     (m_tready)
  );

  assign m_tdata = {res.row, res.col};
  assign m_tuser = res.found;
  assign m_tlast = res.last;

endmodule
